/* rtl/core/bmhq_pkg.sv */
// Shared types and constants for the binary min-heap priority queue.
package bmhq_pkg;

    localparam int KEY_W  = 32;
    localparam int FUNC_W = 2;

    // operation codes carried on the request's func field
    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_LAST,
        S_DN,
        S_DN_L,
        S_DN_R
    } t_state;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic                    empty;
    } t_result;

endpackage

/* rtl/core/bmhq_ram.sv */
// Single-write, single-read heap array with registered read data.
module bmhq_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [$clog2(DEPTH)-1:0]              i_waddr,
    input  logic signed [bmhq_pkg::KEY_W-1:0]     i_wdata,
    input  logic                                  i_re,
    input  logic [$clog2(DEPTH)-1:0]              i_raddr,
    output logic signed [bmhq_pkg::KEY_W-1:0]     o_rdata
);

    logic signed [bmhq_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic signed [bmhq_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bmhq_ctrl.sv */
// Heap sequencer: sift-up / sift-down over the array with one shared comparator.
module bmhq_ctrl #(
    parameter int CAPACITY = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [bmhq_pkg::FUNC_W-1:0]           i_func,
    input  logic signed [bmhq_pkg::KEY_W-1:0]     i_key,
    output logic                                  o_busy,
    output bmhq_pkg::t_result                     o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    bmhq_pkg::t_state r_state, n_state;

    logic [CW-1:0]                     r_cnt, n_cnt;
    logic [AW-1:0]                     r_pos, n_pos;
    logic signed [bmhq_pkg::KEY_W-1:0] r_key, n_key;
    logic signed [bmhq_pkg::KEY_W-1:0] r_bestv, n_bestv;
    logic                              r_best_left, n_best_left;
    logic                              r_has_r, n_has_r;
    logic signed [bmhq_pkg::KEY_W-1:0] r_root;

    // memory port
    logic                              mem_we, mem_re;
    logic [AW-1:0]                     mem_waddr, mem_raddr;
    logic signed [bmhq_pkg::KEY_W-1:0] mem_wdata, mem_rdata;

    // shared comparator: cmp_a < cmp_b, signed
    logic signed [bmhq_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic                              cmp_lt;

    logic [IW-1:0] idx_l, idx_r, cnt_x;
    logic [AW-1:0] idx_par;
    logic          full, empty, take_r, moved;

    bmhq_ram #(.DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign idx_l   = (IW'(r_pos) << 1) + IW'(1);
    assign idx_r   = (IW'(r_pos) << 1) + IW'(2);
    assign cnt_x   = IW'(r_cnt);
    assign idx_par = (r_pos - AW'(1)) >> 1;
    assign full    = (r_cnt == CW'(CAPACITY));
    assign empty   = (r_cnt == '0);
    assign cmp_lt  = (cmp_a < cmp_b);
    assign take_r  = r_has_r && cmp_lt;
    assign moved   = take_r || r_best_left;
    assign o_busy  = (r_state != bmhq_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_func == bmhq_pkg::FUNC_INSERT && !full) begin
                        n_state = bmhq_pkg::S_UP;
                    end else if (i_func == bmhq_pkg::FUNC_EXTRACT && !empty) begin
                        n_state = bmhq_pkg::S_LAST;
                    end
                end
            end
            bmhq_pkg::S_UP: begin
                n_state = (r_pos == '0) ? bmhq_pkg::S_IDLE : bmhq_pkg::S_UP_CMP;
            end
            bmhq_pkg::S_UP_CMP: begin
                n_state = cmp_lt ? bmhq_pkg::S_UP : bmhq_pkg::S_IDLE;
            end
            bmhq_pkg::S_LAST: begin
                n_state = bmhq_pkg::S_DN;
            end
            bmhq_pkg::S_DN: begin
                n_state = (idx_l >= cnt_x) ? bmhq_pkg::S_IDLE : bmhq_pkg::S_DN_L;
            end
            bmhq_pkg::S_DN_L: begin
                n_state = bmhq_pkg::S_DN_R;
            end
            bmhq_pkg::S_DN_R: begin
                n_state = moved ? bmhq_pkg::S_DN : bmhq_pkg::S_IDLE;
            end
            default: begin
                n_state = bmhq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_key       = r_key;
        n_bestv     = r_bestv;
        n_best_left = r_best_left;
        n_has_r     = r_has_r;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_key;
        mem_re      = 1'b0;
        mem_raddr   = r_pos;
        cmp_a       = mem_rdata;
        cmp_b       = r_key;
        o_res       = '0;
        case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_func == bmhq_pkg::FUNC_INSERT && !full) begin
                        n_key = i_key;
                        n_pos = AW'(r_cnt);
                        n_cnt = r_cnt + CW'(1);
                    end
                    if (i_func == bmhq_pkg::FUNC_EXTRACT || i_func == bmhq_pkg::FUNC_PEEK) begin
                        o_res.valid = 1'b1;
                        o_res.empty = empty;
                        o_res.key   = empty ? '0 : r_root;
                    end
                    if (i_func == bmhq_pkg::FUNC_EXTRACT && !empty) begin
                        // fetch the last entry; it becomes the new root
                        n_cnt     = r_cnt - CW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_cnt - CW'(1));
                    end
                end
            end
            bmhq_pkg::S_UP: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_par;
                end
            end
            bmhq_pkg::S_UP_CMP: begin
                // parent strictly greater than the moving key: pull parent down
                cmp_a  = r_key;
                cmp_b  = mem_rdata;
                mem_we = 1'b1;
                if (cmp_lt) begin
                    mem_wdata = mem_rdata;
                    n_pos     = idx_par;
                end
            end
            bmhq_pkg::S_LAST: begin
                n_key = mem_rdata;
                n_pos = '0;
            end
            bmhq_pkg::S_DN: begin
                if (idx_l >= cnt_x) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_l[AW-1:0];
                end
            end
            bmhq_pkg::S_DN_L: begin
                cmp_a       = mem_rdata;
                cmp_b       = r_key;
                n_best_left = cmp_lt;
                n_bestv     = cmp_lt ? mem_rdata : r_key;
                n_has_r     = (idx_r < cnt_x);
                mem_re      = (idx_r < cnt_x);
                mem_raddr   = idx_r[AW-1:0];
            end
            bmhq_pkg::S_DN_R: begin
                // right child wins only when strictly below the current best
                cmp_a  = mem_rdata;
                cmp_b  = r_bestv;
                mem_we = 1'b1;
                if (take_r) begin
                    mem_wdata = mem_rdata;
                    n_pos     = idx_r[AW-1:0];
                end else if (r_best_left) begin
                    mem_wdata = r_bestv;
                    n_pos     = idx_l[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmhq_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_key       <= n_key;
        r_bestv     <= n_bestv;
        r_best_left <= n_best_left;
        r_has_r     <= n_has_r;
        // mirror of entry 0 so peek and extract answer at once
        if (mem_we && mem_waddr == '0) begin
            r_root <= mem_wdata;
        end
    end

endmodule

/* rtl/core/binary_min_heap_queue.sv */
// Top level of the binary min-heap priority queue with request handshake and result buffer.
//
// Usage:
//  Request channel: i_in_valid / o_in_stall with i_func (0 insert, 1 extract min,
//  2 peek min) and i_key_in. A request is taken on a clock edge with valid high
//  and stall low. Result channel: o_out_valid / i_out_stall with o_key_out and
//  o_was_empty; one result per extract or peek, none for insert or code 3.
//  Extract and peek results are formed in the accepting cycle and registered.
//  Requests are handled one at a time; the heap walk runs in a shared compare unit
//  over one memory port. An insert reads each parent in turn and pulls it down while
//  it is greater than the new key, stopping below a smaller-or-equal parent or at the
//  root. An extract moves the last entry to the root and, per level, reads the left
//  and right child and moves the smaller one up while it is below the moving key;
//  peek, an insert into a full heap and code 3 finish in the accepting cycle.
//  o_in_stall stays high while the heap is walked.
//  Reset empties the heap at once (count to zero); no clearing pass.
//  A stalled result sits in the output register; one more result can be held in a
//  skid register, and requests stall while the heap is walked or the skid is occupied.
module binary_min_heap_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [bmhq_pkg::FUNC_W-1:0]           i_func,
    input  logic signed [bmhq_pkg::KEY_W-1:0]     i_key_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [bmhq_pkg::KEY_W-1:0]     o_key_out,
    output logic                                  o_was_empty
);

    logic              accept;
    logic              take;
    logic              busy;
    bmhq_pkg::t_result res;

    // output register and skid register
    logic                              r_out_valid, n_out_valid;
    logic signed [bmhq_pkg::KEY_W-1:0] r_out_key, n_out_key;
    logic                              r_out_empty, n_out_empty;
    logic                              r_skid_valid, n_skid_valid;
    logic signed [bmhq_pkg::KEY_W-1:0] r_skid_key, n_skid_key;
    logic                              r_skid_empty, n_skid_empty;

    assign o_in_stall = busy || r_skid_valid;
    assign accept     = i_in_valid && !o_in_stall;
    assign take       = r_out_valid && !i_out_stall;

    bmhq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_func  (i_func),
        .i_key   (i_key_in),
        .o_busy  (busy),
        .o_res   (res)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_key    = r_out_key;
        n_out_empty  = r_out_empty;
        n_skid_valid = r_skid_valid;
        n_skid_key   = r_skid_key;
        n_skid_empty = r_skid_empty;
        // drain: skid moves up when the output is taken
        if (take) begin
            n_out_valid  = r_skid_valid;
            n_out_key    = r_skid_key;
            n_out_empty  = r_skid_empty;
            n_skid_valid = 1'b0;
        end
        // fill: new result lands in output if free, else in the (empty) skid
        if (res.valid) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out_key   = res.key;
                n_out_empty = res.empty;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_key   = res.key;
                n_skid_empty = res.empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_key    <= n_out_key;
        r_out_empty  <= n_out_empty;
        r_skid_key   <= n_skid_key;
        r_skid_empty <= n_skid_empty;
    end

    assign o_out_valid = r_out_valid;
    assign o_key_out   = r_out_key;
    assign o_was_empty = r_out_empty;

endmodule
